// ----- hdl/tssu_pkg.sv -----
// ----------------------------------------------------------------------------
// tssu_pkg
// shared types and constants for the thumb stack scan unwinder
// ----------------------------------------------------------------------------
`default_nettype none

package tssu_pkg;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_CODE_LOW     = 3'd0;
    localparam logic [2:0] REG_CODE_HIGH    = 3'd1;
    localparam logic [2:0] REG_RAM_LOW      = 3'd2;
    localparam logic [2:0] REG_RAM_HIGH     = 3'd3;
    localparam logic [2:0] REG_FILL_PATTERN = 3'd4;
    localparam logic [2:0] REG_MAX_FRAMES   = 3'd5;

    localparam int unsigned ADDR_W = 5;

    localparam logic [6:0] MAX_FRAMES_RESET = 7'd16;
    localparam logic [6:0] FRAME_CAP        = 7'd64;

    // call encodings in the halfwords just below a return address
    localparam logic [15:0] BLX_REG_MASK  = 16'hFF87;
    localparam logic [15:0] BLX_REG_MATCH = 16'h4780;
    localparam logic [15:0] BL_HI_MASK    = 16'hF800;
    localparam logic [15:0] BL_HI_MATCH   = 16'hF000;
    localparam logic [15:0] BL_LO_MASK    = 16'hD000;
    localparam logic [15:0] BL_LO_MATCH   = 16'hD000;

    // one classified stack word, passed from front to back
    typedef struct packed {
        logic        start_walk;
        logic        in_ram;
        logic        fill_hit;
        logic        call_site;
        logic [31:0] clean_address;
        logic [31:0] stack_word;
        logic [31:0] address_plus4;
        logic [31:0] address_minus4;
    } word_class_t;

    typedef struct packed {
        logic [31:0] code_low;
        logic [31:0] code_high;
        logic [31:0] ram_low;
        logic [31:0] ram_high;
        logic [31:0] fill_pattern;
    } range_cfg_t;

endpackage

`default_nettype wire

// ----- hdl/tssu_front.sv -----
// ----------------------------------------------------------------------------
// tssu_front
// classifies each incoming stack word against the configured ranges
// ----------------------------------------------------------------------------
`default_nettype none

module tssu_front (
    input  wire logic                  start_walk,
    input  wire logic [31:0]           word_address,
    input  wire logic [31:0]           stack_word,
    input  wire logic [15:0]           halfword_before_minus4,
    input  wire logic [15:0]           halfword_before_minus2,
    input  wire tssu_pkg::range_cfg_t  cfg,
    output tssu_pkg::word_class_t      word_class
);

    logic [32:0] code_floor;
    logic [31:0] clean;
    logic        in_code;
    logic        blx_reg;
    logic        bl_imm;

    always_comb
    begin
        clean      = {stack_word[31:1], 1'b0};
        // floor computed one bit wider so it never wraps
        code_floor = {1'b0, cfg.code_low} + 33'd4;
        in_code    = ({1'b0, clean} >= code_floor) && (clean < cfg.code_high);
        blx_reg    = (halfword_before_minus2 & tssu_pkg::BLX_REG_MASK)
                     == tssu_pkg::BLX_REG_MATCH;
        bl_imm     = ((halfword_before_minus4 & tssu_pkg::BL_HI_MASK)
                      == tssu_pkg::BL_HI_MATCH)
                     && ((halfword_before_minus2 & tssu_pkg::BL_LO_MASK)
                      == tssu_pkg::BL_LO_MATCH);

        word_class.start_walk     = start_walk;
        word_class.in_ram         = (word_address >= cfg.ram_low)
                                    && (word_address < cfg.ram_high);
        word_class.fill_hit       = (cfg.fill_pattern != 32'd0)
                                    && (stack_word == cfg.fill_pattern);
        word_class.call_site      = stack_word[0] && in_code && (blx_reg || bl_imm);
        word_class.clean_address  = clean;
        word_class.stack_word     = stack_word;
        word_class.address_plus4  = word_address + 32'd4;
        word_class.address_minus4 = word_address - 32'd4;
    end

endmodule

`default_nettype wire

// ----- hdl/tssu_queue.sv -----
// ----------------------------------------------------------------------------
// tssu_queue
// two-entry queue of classified words between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module tssu_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire tssu_pkg::word_class_t  push_data,
    output logic                        full,
    input  wire logic                   pop,
    output tssu_pkg::word_class_t       pop_data,
    output logic                        not_empty
);

    tssu_pkg::word_class_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    always_comb
    begin
        full      = (count_reg == 2'd2);
        not_empty = (count_reg != 2'd0);
        do_push   = push && !full;
        do_pop    = pop && not_empty;
        pop_data  = entry_reg[rd_ptr_reg];

        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

endmodule

`default_nettype wire

// ----- hdl/tssu_back.sv -----
// ----------------------------------------------------------------------------
// tssu_back
// walk state, frame acceptance and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module tssu_back #(
    parameter int unsigned SCAN_WORDS = 256,
    parameter int unsigned LINK_SLACK = 128
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [6:0]             max_frames,
    input  wire logic                   word_valid,
    input  wire tssu_pkg::word_class_t  word_class,
    output logic                        word_take,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic                        frame_found,
    output logic [31:0]                 return_address,
    output logic [5:0]                  frame_number,
    output logic                        walk_ended,
    output logic [6:0]                  frame_count
);

    localparam int unsigned WORDS_W = $clog2(SCAN_WORDS + 1);
    localparam logic [WORDS_W-1:0] WORDS_MAX = WORDS_W'(SCAN_WORDS);
    localparam logic [31:0] SLACK = 32'(LINK_SLACK);

    logic [31:0]        prev_word_reg;
    logic [31:0]        prev_word_next;
    logic [31:0]        last_link_reg;
    logic [31:0]        last_link_next;
    logic [6:0]         frames_reg;
    logic [6:0]         frames_next;
    logic [WORDS_W-1:0] words_reg;
    logic [WORDS_W-1:0] words_next;
    logic               active_reg;
    logic               active_next;

    logic               out_valid_reg;
    logic               found_reg;
    logic               found_next;
    logic [31:0]        ret_reg;
    logic [31:0]        ret_next;
    logic [5:0]         num_reg;
    logic [5:0]         num_next;

    logic [6:0]         limit;
    logic [31:0]        distance;
    logic               hit;

    always_comb
    begin
        limit     = (max_frames > tssu_pkg::FRAME_CAP) ? tssu_pkg::FRAME_CAP : max_frames;
        word_take = word_valid && (!out_valid_reg || out_ready);

        // start of walk clears state before the word is handled
        prev_word_next = word_class.start_walk ? 32'd0 : prev_word_reg;
        last_link_next = word_class.start_walk ? 32'd0 : last_link_reg;
        frames_next    = word_class.start_walk ? 7'd0 : frames_reg;
        words_next     = word_class.start_walk ? '0 : words_reg;
        active_next    = word_class.start_walk || active_reg;

        distance   = prev_word_next - word_class.address_plus4;
        hit        = 1'b0;
        found_next = 1'b0;
        ret_next   = 32'd0;
        num_next   = 6'd0;

        if (active_next)
        begin
            if ((frames_next >= limit) || (words_next >= WORDS_MAX)
                || !word_class.in_ram || word_class.fill_hit)
            begin
                active_next = 1'b0;
            end
            else
            begin
                words_next = words_next + WORDS_W'(1);
                hit = word_class.call_site && (distance <= SLACK)
                      && ((frames_next == 7'd0)
                          || ((prev_word_next > last_link_next)
                              && (word_class.address_minus4 > last_link_next)));
                if (hit)
                begin
                    found_next     = 1'b1;
                    ret_next       = word_class.clean_address;
                    num_next       = frames_next[5:0];
                    frames_next    = frames_next + 7'd1;
                    last_link_next = prev_word_next;
                end
                prev_word_next = word_class.stack_word;
                if ((frames_next >= limit) || (words_next >= WORDS_MAX))
                begin
                    active_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_word_reg <= 32'd0;
            last_link_reg <= 32'd0;
            frames_reg    <= 7'd0;
            words_reg     <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (word_take)
            begin
                prev_word_reg <= prev_word_next;
                last_link_reg <= last_link_next;
                frames_reg    <= frames_next;
                words_reg     <= words_next;
                active_reg    <= active_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (word_take)
        begin
            found_reg <= found_next;
            ret_reg   <= ret_next;
            num_reg   <= num_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign frame_found    = found_reg;
    assign return_address = ret_reg;
    assign frame_number   = num_reg;
    assign walk_ended     = !active_reg;
    assign frame_count    = frames_reg;

    a_frames_cap : assert property (@(posedge clk) disable iff (!rst_n)
        frames_reg <= tssu_pkg::FRAME_CAP)
        else $error("frame count above cap");

    a_words_cap : assert property (@(posedge clk) disable iff (!rst_n)
        words_reg <= WORDS_MAX)
        else $error("word counter above scan limit");

    a_found_clean : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && found_reg) |-> (ret_reg[0] == 1'b0 && frames_reg != 7'd0))
        else $error("found frame with odd address or zero count");

    a_hit_counts : assert property (@(posedge clk) disable iff (!rst_n)
        (word_take && found_next) |=> (frames_reg == $past(frames_next)
                                       && frames_reg != 7'd0))
        else $error("accepted frame not counted");

endmodule

`default_nettype wire

// ----- hdl/thumb_stack_scan_unwinder.sv -----
// ----------------------------------------------------------------------------
// thumb_stack_scan_unwinder
// scans stack words for thumb return addresses that follow a call and sit
// above a rising chain of saved frame links
// ----------------------------------------------------------------------------
//  channel   handshake                    payload
//  in        in_valid / in_ready          start_walk, word_address, stack_word,
//                                         halfword_before_minus4/2
//  out       out_valid / out_ready        frame_found, return_address,
//                                         frame_number, walk_ended, frame_count
//  cfg       psel/penable/pwrite/pready   paddr, pwdata, prdata (apb-style)
//
//  one word per cycle sustained while out_ready keeps up; a taken word passes
//  through a queue entry, then the result register
//  the rate is set by the back end's walk-state update, one word per cycle
//  reset clears the queue, walk state and config registers; max_frames resets to 16
//  the two-entry queue lets the front keep taking words while a result waits
//  on out_ready; in_ready drops only when the queue is full
// ----------------------------------------------------------------------------
`default_nettype none

module thumb_stack_scan_unwinder #(
    parameter int unsigned SCAN_WORDS = 256,
    parameter int unsigned LINK_SLACK = 128
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,

    // stack word input
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         start_walk,
    input  wire logic [31:0]                  word_address,
    input  wire logic [31:0]                  stack_word,
    input  wire logic [15:0]                  halfword_before_minus4,
    input  wire logic [15:0]                  halfword_before_minus2,

    // result output
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              frame_found,
    output logic [31:0]                       return_address,
    output logic [5:0]                        frame_number,
    output logic                              walk_ended,
    output logic [6:0]                        frame_count,

    // configuration
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [tssu_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    // configuration registers
    logic [31:0] code_low_reg;
    logic [31:0] code_high_reg;
    logic [31:0] ram_low_reg;
    logic [31:0] ram_high_reg;
    logic [31:0] fill_pattern_reg;
    logic [6:0]  max_frames_reg;

    logic [2:0]  reg_index;
    logic        cfg_write;

    tssu_pkg::range_cfg_t  range_cfg;
    tssu_pkg::word_class_t front_class;
    tssu_pkg::word_class_t back_class;
    logic                  queue_full;
    logic                  queue_not_empty;
    logic                  back_take;

    assign pready    = 1'b1;
    assign reg_index = paddr[tssu_pkg::ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_low_reg     <= 32'd0;
            code_high_reg    <= 32'd0;
            ram_low_reg      <= 32'd0;
            ram_high_reg     <= 32'd0;
            fill_pattern_reg <= 32'd0;
            max_frames_reg   <= tssu_pkg::MAX_FRAMES_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                tssu_pkg::REG_CODE_LOW:     code_low_reg     <= pwdata;
                tssu_pkg::REG_CODE_HIGH:    code_high_reg    <= pwdata;
                tssu_pkg::REG_RAM_LOW:      ram_low_reg      <= pwdata;
                tssu_pkg::REG_RAM_HIGH:     ram_high_reg     <= pwdata;
                tssu_pkg::REG_FILL_PATTERN: fill_pattern_reg <= pwdata;
                tssu_pkg::REG_MAX_FRAMES:   max_frames_reg   <= pwdata[6:0];
                default:                    ;
            endcase
        end
    end

    // register read mux
    always_comb
    begin
        case (reg_index)
            tssu_pkg::REG_CODE_LOW:     prdata = code_low_reg;
            tssu_pkg::REG_CODE_HIGH:    prdata = code_high_reg;
            tssu_pkg::REG_RAM_LOW:      prdata = ram_low_reg;
            tssu_pkg::REG_RAM_HIGH:     prdata = ram_high_reg;
            tssu_pkg::REG_FILL_PATTERN: prdata = fill_pattern_reg;
            tssu_pkg::REG_MAX_FRAMES:   prdata = {25'd0, max_frames_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        range_cfg.code_low     = code_low_reg;
        range_cfg.code_high    = code_high_reg;
        range_cfg.ram_low      = ram_low_reg;
        range_cfg.ram_high     = ram_high_reg;
        range_cfg.fill_pattern = fill_pattern_reg;
    end

    // front: range, fill and call-site checks that need no walk state
    tssu_front u_front (
        .start_walk             (start_walk),
        .word_address           (word_address),
        .stack_word             (stack_word),
        .halfword_before_minus4 (halfword_before_minus4),
        .halfword_before_minus2 (halfword_before_minus2),
        .cfg                    (range_cfg),
        .word_class             (front_class)
    );

    assign in_ready = !queue_full;

    tssu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid),
        .push_data (front_class),
        .full      (queue_full),
        .pop       (back_take),
        .pop_data  (back_class),
        .not_empty (queue_not_empty)
    );

    // back: link distance, chain order, limits and the result word
    tssu_back #(
        .SCAN_WORDS (SCAN_WORDS),
        .LINK_SLACK (LINK_SLACK)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .max_frames     (max_frames_reg),
        .word_valid     (queue_not_empty),
        .word_class     (back_class),
        .word_take      (back_take),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .frame_found    (frame_found),
        .return_address (return_address),
        .frame_number   (frame_number),
        .walk_ended     (walk_ended),
        .frame_count    (frame_count)
    );

endmodule

`default_nettype wire
